// ----- design/trgb_pkg.sv -----
// Shared types and constants for the touch RGB LED PWM fader.
package trgb_pkg;

  localparam int CHAN_W  = 8;
  localparam int CALIB_W = 6;
  localparam int BASE_W  = 9;

  localparam logic [CHAN_W-1:0] BLINK_LEVEL = 8'd5;

  typedef enum logic [1:0] {
    REQ_PWM    = 2'd0,
    REQ_FADE   = 2'd1,
    REQ_SAMPLE = 2'd2
  } req_type_t;

  typedef struct packed {
    logic              fade;
    logic              blink;
    logic [CHAN_W-1:0] blink_val;
    logic              retarget;
    logic              touch;
  } trgb_ctl_t;

  typedef struct packed {
    logic touched;
    logic calibrated;
    logic fast_fade;
  } trgb_stat_t;

  typedef struct packed {
    logic red_on;
    logic green_on;
    logic blue_on;
    logic fade_done;
    logic touched;
    logic calibrated;
    logic fast_fade;
  } trgb_rsp_t;

endpackage

// ----- design/trgb_in_if.sv -----
// Request channel: valid/ready handshake with request payload.
interface trgb_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] sensor_count;
  logic [7:0] random_red;
  logic [7:0] random_green;
  logic [7:0] random_blue;

  modport source (output valid, req_type, sensor_count, random_red, random_green,
                  random_blue, input ready);
  modport sink (input valid, req_type, sensor_count, random_red, random_green,
                random_blue, output ready);
endinterface

// ----- design/trgb_out_if.sv -----
// Result channel: valid/ready handshake with pin and status payload.
interface trgb_out_if;
  logic valid;
  logic ready;
  logic red_on;
  logic green_on;
  logic blue_on;
  logic fade_done;
  logic touched;
  logic calibrated;
  logic fast_fade;

  modport source (output valid, red_on, green_on, blue_on, fade_done, touched,
                  calibrated, fast_fade, input ready);
  modport sink (input valid, red_on, green_on, blue_on, fade_done, touched,
                calibrated, fast_fade, output ready);
endinterface

// ----- design/trgb_chan.sv -----
// One color channel: level and target registers, fade step, blink and retarget.
module trgb_chan import trgb_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  trgb_ctl_t         ctl,
  input  logic [CHAN_W-1:0] random_level,
  output logic [CHAN_W-1:0] level,
  output logic              match_next
);

  logic [CHAN_W-1:0] target;
  logic [CHAN_W-1:0] level_next;
  logic [CHAN_W-1:0] target_next;

  always_comb begin
    level_next  = level;
    target_next = target;
    if (ctl.blink) begin
      level_next  = ctl.blink_val;
      target_next = ctl.blink_val;
    end else if (ctl.retarget) begin
      target_next = ctl.touch ? random_level : '0;
    end else if (ctl.fade) begin
      if (level < target) begin
        level_next = level + CHAN_W'(1);
      end else if (level > target) begin
        level_next = level - CHAN_W'(1);
      end
    end
  end

  assign match_next = (level_next == target_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      level  <= '0;
      target <= '0;
    end else begin
      level  <= level_next;
      target <= target_next;
    end
  end

endmodule

// ----- design/trgb_sense.sv -----
// Touch sensing: calibration counter, baseline/threshold, touch and pacing flags.
module trgb_sense import trgb_pkg::*; #(
  parameter int CALIB_SAMPLES = 50
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              fade,
  input  logic              sample,
  input  logic [CHAN_W-1:0] sensor_count,
  input  logic              red_lit,
  output trgb_ctl_t         ctl,
  output trgb_stat_t        stat
);

  localparam logic [CALIB_W-1:0] CALIB_N = CALIB_W'(CALIB_SAMPLES);

  logic [CALIB_W-1:0] calib_taken;
  logic [CALIB_W-1:0] calib_taken_next;
  logic [BASE_W-1:0]  baseline_level;
  logic [BASE_W-1:0]  baseline_level_next;
  logic               touch_flag;
  logic               touch_flag_next;
  logic               fast_mode;
  logic               fast_mode_next;
  logic [BASE_W:0]    base_sum;
  logic [BASE_W-1:0]  base_avg;
  logic               cal;
  logic               over;

  assign cal      = (calib_taken >= CALIB_N);
  assign over     = ({1'b0, sensor_count} > baseline_level);
  assign base_sum = {1'b0, baseline_level} + {{(BASE_W-CHAN_W+1){1'b0}}, sensor_count};
  assign base_avg = (baseline_level != '0) ? base_sum[BASE_W:1]
                                            : {{(BASE_W-CHAN_W){1'b0}}, sensor_count};

  always_comb begin
    calib_taken_next    = calib_taken;
    baseline_level_next = baseline_level;
    touch_flag_next     = touch_flag;
    fast_mode_next      = fast_mode;
    if (sample && !cal) begin
      calib_taken_next = calib_taken + CALIB_W'(1);
      if (calib_taken_next >= CALIB_N) begin
        baseline_level_next = base_avg + {4'b0, base_avg[BASE_W-1:4]};
      end else begin
        baseline_level_next = base_avg;
      end
    end else if (sample) begin
      touch_flag_next = over;
      fast_mode_next  = over;
    end
  end

  assign ctl.fade      = fade;
  assign ctl.blink     = sample && !cal;
  assign ctl.blink_val = red_lit ? '0 : BLINK_LEVEL;
  assign ctl.retarget  = sample && cal;
  assign ctl.touch     = over;

  assign stat.touched    = touch_flag_next;
  assign stat.calibrated = (calib_taken_next >= CALIB_N);
  assign stat.fast_fade  = fast_mode_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      calib_taken    <= '0;
      baseline_level <= '0;
      touch_flag     <= 1'b0;
      fast_mode      <= 1'b0;
    end else begin
      calib_taken    <= calib_taken_next;
      baseline_level <= baseline_level_next;
      touch_flag     <= touch_flag_next;
      fast_mode      <= fast_mode_next;
    end
  end

endmodule

// ----- design/touch_rgb_led_pwm_fader.sv -----
// Throughput: one request per cycle while the skid slot is free; a full skid slot stalls
// input. The request is registered, processed in one pass against the fader state, and
// its result goes to an output register with a skid slot.
// Reset (synchronous, active high) clears the PWM counter, levels, targets,
// calibration count, baseline and touch/pacing flags, and empties all stages.
module touch_rgb_led_pwm_fader import trgb_pkg::*; #(
  parameter int CALIB_SAMPLES = 50
) (
  input logic       clk,
  input logic       rst,
  trgb_in_if.sink   req,
  trgb_out_if.source rsp
);

  logic              s1_valid;
  logic [1:0]        s1_type;
  logic [CHAN_W-1:0] s1_count;
  logic [CHAN_W-1:0] s1_red;
  logic [CHAN_W-1:0] s1_green;
  logic [CHAN_W-1:0] s1_blue;

  logic              drain;
  logic              is_pwm;
  logic              is_fade;
  logic              is_sample;
  logic [CHAN_W-1:0] pwm_count;
  logic [CHAN_W-1:0] red_level;
  logic [CHAN_W-1:0] green_level;
  logic [CHAN_W-1:0] blue_level;
  logic              red_match;
  logic              green_match;
  logic              blue_match;
  trgb_ctl_t         ctl;
  trgb_stat_t        stat;
  trgb_rsp_t         result;

  logic              out_valid;
  trgb_rsp_t         out_q;
  logic              skid_valid;
  trgb_rsp_t         skid_q;
  logic              out_take;

  assign drain     = s1_valid && !skid_valid;
  assign req.ready = !s1_valid || drain;
  assign is_pwm    = drain && (s1_type == REQ_PWM);
  assign is_fade   = drain && (s1_type == REQ_FADE);
  assign is_sample = drain && (s1_type == REQ_SAMPLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      s1_type  <= req.req_type;
      s1_count <= req.sensor_count;
      s1_red   <= req.random_red;
      s1_green <= req.random_green;
      s1_blue  <= req.random_blue;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pwm_count <= '0;
    end else if (is_pwm) begin
      pwm_count <= pwm_count + CHAN_W'(1);
    end
  end

  trgb_sense #(.CALIB_SAMPLES(CALIB_SAMPLES)) u_sense (
    .clk          (clk),
    .rst          (rst),
    .fade         (is_fade),
    .sample       (is_sample),
    .sensor_count (s1_count),
    .red_lit      (red_level != '0),
    .ctl          (ctl),
    .stat         (stat)
  );

  trgb_chan u_red (
    .clk (clk), .rst (rst), .ctl (ctl), .random_level (s1_red),
    .level (red_level), .match_next (red_match)
  );

  trgb_chan u_green (
    .clk (clk), .rst (rst), .ctl (ctl), .random_level (s1_green),
    .level (green_level), .match_next (green_match)
  );

  trgb_chan u_blue (
    .clk (clk), .rst (rst), .ctl (ctl), .random_level (s1_blue),
    .level (blue_level), .match_next (blue_match)
  );

  assign result.red_on     = is_pwm && (pwm_count < red_level);
  assign result.green_on   = is_pwm && (pwm_count < {1'b0, green_level[CHAN_W-1:1]});
  assign result.blue_on    = is_pwm && (pwm_count < blue_level);
  assign result.fade_done  = red_match && green_match && blue_match;
  assign result.touched    = stat.touched;
  assign result.calibrated = stat.calibrated;
  assign result.fast_fade  = stat.fast_fade;

  // output register plus one skid slot
  assign out_take = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_take) begin
      out_valid  <= skid_valid || drain;
      skid_valid <= 1'b0;
    end else if (drain) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_take) begin
      out_q <= skid_valid ? skid_q : result;
    end else if (drain) begin
      skid_q <= result;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.red_on     = out_q.red_on;
  assign rsp.green_on   = out_q.green_on;
  assign rsp.blue_on    = out_q.blue_on;
  assign rsp.fade_done  = out_q.fade_done;
  assign rsp.touched    = out_q.touched;
  assign rsp.calibrated = out_q.calibrated;
  assign rsp.fast_fade  = out_q.fast_fade;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid slot full while output register empty");

  a_touch_fast: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_q.touched == out_q.fast_fade))
    else $error("touch flag and fast pacing disagree");

  a_touch_needs_cal: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_q.touched) |-> out_q.calibrated)
    else $error("touch reported before calibration finished");

  a_full_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && skid_valid) |-> !req.ready)
    else $error("request accepted with both result slots and input stage full");

endmodule

// ----- sim/tb_top.sv -----
// Testbench for touch_rgb_led_pwm_fader: a directed table, then random touch episodes, each beat scored.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import trgb_pkg::*;

  localparam int N_CALIB = 50;
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int IDLE_PCT = 18;
  localparam int RAND_ITEMS = 600;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 8;
  localparam trgb_rsp_t RSP_AT_REST = '{fade_done: 1'b1, default: 1'b0};

  typedef struct {
    logic [1:0] kind;
    logic [7:0] cnt;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    bit         typed;
    trgb_rsp_t  want;
  } led_row_t;

  localparam int N_ROWS = 16;
  led_row_t plan [N_ROWS] = '{
    '{REQ_PWM,    8'h00, 8'h00, 8'h00, 8'h00, 1'b1, RSP_AT_REST},
    '{REQ_FADE,   8'h00, 8'h00, 8'h00, 8'h00, 1'b1, RSP_AT_REST},
    '{REQ_UNUSED, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, RSP_AT_REST},
    '{REQ_SAMPLE, 8'h00, 8'hFF, 8'hFF, 8'hFF, 1'b1, RSP_AT_REST},
    '{REQ_PWM,    8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 7'b1111000},
    '{REQ_SAMPLE, 8'd200, 8'h00, 8'h00, 8'h00, 1'b0, '0},
    '{REQ_SAMPLE, 8'd100, 8'h00, 8'h00, 8'h00, 1'b0, '0},
    '{REQ_SAMPLE, 8'd255, 8'h00, 8'h00, 8'h00, 1'b0, '0},
    '{REQ_SAMPLE, 8'd0,   8'h00, 8'h00, 8'h00, 1'b0, '0},
    '{REQ_PWM,    8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 7'b1011000},
    '{REQ_FADE,   8'hFF, 8'hFF, 8'h00, 8'hFF, 1'b0, '0},
    '{REQ_UNUSED, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, '0},
    '{REQ_SAMPLE, 8'hAA, 8'h55, 8'hAA, 8'h0F, 1'b0, '0},
    '{REQ_PWM,    8'h55, 8'hAA, 8'h55, 8'hF0, 1'b0, '0},
    '{REQ_SAMPLE, 8'h01, 8'hFF, 8'hFF, 8'hFF, 1'b0, '0},
    '{REQ_FADE,   8'h00, 8'h00, 8'h00, 8'h00, 1'b0, '0}
  };

  string rsp_field [7] = '{"red_on", "green_on", "blue_on", "fade_done", "touched",
                           "calibrated", "fast_fade"};

  logic clk;
  logic rst;
  int   cycles = 0;
  int   errors = 0;
  int   rsp_beats = 0;
  int   rand_sent = 0;
  bit   no_gaps = 1'b0;
  int   n_kind [4] = '{0, 0, 0, 0};
  int   n_touch = 0;
  int   n_settled = 0;

  trgb_rsp_t led_rsp_due [$];

  // fader state as seen from outside
  logic [7:0] pwm_cnt;
  logic [7:0] lvl [3];
  logic [7:0] tgt [3];
  logic [5:0] calib_cnt;
  logic [8:0] base_thr;
  logic       touch_flag;
  logic       fast_flag;

  trgb_in_if  req_if ();
  trgb_out_if rsp_if ();

  touch_rgb_led_pwm_fader #(.CALIB_SAMPLES(N_CALIB)) u_top (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  task automatic advance_fader(input logic [1:0] kind, input logic [7:0] cnt, r, g, b,
                               output trgb_rsp_t rsp);
    logic [9:0] sum;
    logic [7:0] blink;
    rsp = '0;
    case (kind)
      REQ_PWM: begin
        rsp.red_on   = pwm_cnt < lvl[0];
        rsp.green_on = pwm_cnt < (lvl[1] >> 1);
        rsp.blue_on  = pwm_cnt < lvl[2];
        pwm_cnt = pwm_cnt + 8'd1;
      end
      REQ_FADE: begin
        for (int c = 0; c < 3; c++)
          if (lvl[c] < tgt[c]) lvl[c] = lvl[c] + 8'd1;
          else if (lvl[c] > tgt[c]) lvl[c] = lvl[c] - 8'd1;
      end
      REQ_SAMPLE: begin
        if (calib_cnt < N_CALIB) begin
          sum = {1'b0, base_thr} + {2'b00, cnt};
          base_thr = (base_thr != 9'd0) ? sum[9:1] : {1'b0, cnt};
          blink = (lvl[0] != 8'd0) ? 8'd0 : BLINK_LEVEL;
          for (int c = 0; c < 3; c++) begin
            lvl[c] = blink;
            tgt[c] = blink;
          end
          calib_cnt = calib_cnt + 6'd1;
          if (calib_cnt >= N_CALIB) base_thr = base_thr + (base_thr >> 4);
        end else if ({1'b0, cnt} > base_thr) begin
          touch_flag = 1'b1;
          fast_flag  = 1'b1;
          tgt[0] = r;
          tgt[1] = g;
          tgt[2] = b;
        end else begin
          touch_flag = 1'b0;
          fast_flag  = 1'b0;
          for (int c = 0; c < 3; c++) tgt[c] = 8'd0;
        end
      end
      default: ;
    endcase
    rsp.fade_done  = (lvl[0] == tgt[0]) && (lvl[1] == tgt[1]) && (lvl[2] == tgt[2]);
    rsp.touched    = touch_flag;
    rsp.calibrated = calib_cnt >= N_CALIB;
    rsp.fast_fade  = fast_flag;
  endtask

  task automatic send_beat(input logic [1:0] kind, input logic [7:0] cnt, r, g, b,
                           input bit typed, input trgb_rsp_t want);
    trgb_rsp_t rsp;
    while (!no_gaps && $urandom_range(99) < IDLE_PCT) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid        <= 1'b1;
    req_if.req_type     <= kind;
    req_if.sensor_count <= cnt;
    req_if.random_red   <= r;
    req_if.random_green <= g;
    req_if.random_blue  <= b;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    advance_fader(kind, cnt, r, g, b, rsp);
    led_rsp_due.push_back(typed ? want : rsp);
    n_kind[kind]++;
    if (kind == REQ_SAMPLE && rsp.calibrated && rsp.touched) n_touch++;
    if (kind == REQ_FADE && rsp.calibrated && rsp.fade_done) n_settled++;
  endtask

  function automatic logic [7:0] pick_color();
    return $urandom_range(1) ? 8'($urandom_range(15)) : 8'($urandom_range(255));
  endfunction

  task automatic run_filler(input int len);
    int pick;
    logic [1:0] kind;
    for (int i = 0; i < len; i++) begin
      pick = $urandom_range(99);
      kind = (pick < 45) ? REQ_PWM : (pick < 90) ? REQ_FADE : REQ_UNUSED;
      send_beat(kind, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 1'b0, '0);
      rand_sent++;
    end
  endtask

  task automatic flag_mismatch(input string what);
    $display("[%0t] result beat %0d: %s", $realtime, rsp_beats, what);
    errors++;
  endtask

  always @(posedge clk) begin
    trgb_rsp_t got;
    trgb_rsp_t want;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      got = '{rsp_if.red_on, rsp_if.green_on, rsp_if.blue_on, rsp_if.fade_done,
              rsp_if.touched, rsp_if.calibrated, rsp_if.fast_fade};
      if (led_rsp_due.size() == 0) begin
        flag_mismatch("beat with nothing pending");
      end else begin
        want = led_rsp_due.pop_front();
        for (int i = 6; i >= 0; i--)
          if (got[i] !== want[i])
            flag_mismatch($sformatf("%s got %b want %b", rsp_field[6-i], got[i], want[i]));
      end
      rsp_beats++;
    end
    rsp_if.ready <= no_gaps || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats pending", cycles, led_rsp_due.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int thr;
    logic [7:0] cnt;
    rst = 1'b1;
    req_if.valid = 1'b0;
    req_if.req_type = REQ_PWM;
    req_if.sensor_count = 8'd0;
    req_if.random_red = 8'd0;
    req_if.random_green = 8'd0;
    req_if.random_blue = 8'd0;
    rsp_if.ready = 1'b0;
    pwm_cnt = 8'd0;
    for (int c = 0; c < 3; c++) begin
      lvl[c] = 8'd0;
      tgt[c] = 8'd0;
    end
    calib_cnt = 6'd0;
    base_thr = 9'd0;
    touch_flag = 1'b0;
    fast_flag = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i])
      send_beat(plan[i].kind, plan[i].cnt, plan[i].r, plan[i].g, plan[i].b,
                plan[i].typed, plan[i].want);

    // finish calibration with moderate counts so touches stay reachable
    while (calib_cnt < N_CALIB) begin
      cnt = ($urandom_range(11) == 0) ? 8'd0 : 8'($urandom_range(160, 64));
      send_beat(REQ_SAMPLE, cnt, pick_color(), pick_color(), pick_color(), 1'b0, '0);
      rand_sent++;
      run_filler($urandom_range(3));
    end

    // touch episodes: a sample around the threshold, then a run of ticks, fade steps and unused requests
    while (rand_sent < RAND_ITEMS) begin
      no_gaps <= (rand_sent >= 250 && rand_sent < 380);
      thr = base_thr;
      case ($urandom_range(3))
        0: cnt = 8'($urandom_range(255, (thr < 255) ? thr + 1 : 255));
        1: cnt = 8'($urandom_range((thr < 255) ? thr : 255));
        2: cnt = 8'((thr < 255) ? thr : 255);
        default: cnt = 8'((thr < 255) ? thr + 1 : 255);
      endcase
      send_beat(REQ_SAMPLE, cnt, pick_color(), pick_color(), pick_color(), 1'b0, '0);
      rand_sent++;
      run_filler($urandom_range(40));
    end
    req_if.valid <= 1'b0;
    no_gaps <= 1'b0;

    while (led_rsp_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d PWM ticks, %0d fade steps, %0d sensor samples, %0d unused requests.",
             n_kind[REQ_PWM], n_kind[REQ_FADE], n_kind[REQ_SAMPLE], n_kind[REQ_UNUSED]);
    $display("Touches %0d, settled fades %0d, threshold %0d, %0d result beats, %0d errors.",
             n_touch, n_settled, base_thr, rsp_beats, errors);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
